[rtl/core/salc_pkg.sv]
// Shared types and codes for the set-associative LRU cache model.
// Used by the cache top level; depends on nothing else.
package salc_pkg;

  // Access kinds carried on the input channel.
  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_STORE  = 2'd1;
  localparam logic [1:0] MODE_MODIFY = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  // Result kinds.
  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_FILL  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [1:0] CFG_WAYS       = 2'd2;

  // Field limits.
  localparam logic [2:0] SET_BITS_MAX   = 3'd6;
  localparam logic [4:0] BLOCK_BITS_MAX = 5'd26;
  localparam logic [2:0] RANK_MAX       = 3'd7;
  localparam int         MAX_WAYS       = 8;
  localparam int         SET_CODES      = 64;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] address;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [5:0]  set_index;
    logic [31:0] line_tag;
    logic [25:0] blk_off;
    logic [31:0] evicted_tag;
    logic        last;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
    logic [31:0] eviction_count;
    logic [31:0] access_count;
  } out_beat_t;

  // One way of a set as held in the row memory.
  typedef struct packed {
    logic        valid;
    logic [2:0]  rank;
    logic [31:0] tag;
  } way_ent_t;

endpackage

[rtl/core/set_assoc_lru_cache_sim_top.sv]
// Top level of the set-associative LRU cache model: address split, set lookup,
// LRU update and running counters. Depends on salc_pkg and salc_ram.
//
//  Channel | Ports                              | Beat
//  --------+------------------------------------+---------------------------------
//  input   | in_valid, in_stall, in_payload     | one access request (mode, address)
//  output  | out_valid, out_stall, out_payload  | one result per cache access
//  config  | cfg_we, cfg_index, cfg_wdata       | one register write
//
// For a load or store the set row is read from the row memory in the accept cycle,
// then checked, updated and written back once the output register is free.
// A modify makes two passes; its second access works on the forwarded row of the first.
// After reset a clearing pass writes every row, with input stalled.
// A result waits in the output register while out_stall is high; a new beat is
// still accepted, and its lookup holds until the output register is free.
module set_assoc_lru_cache_sim_top
  import salc_pkg::*;
#(
  parameter int SETS = 64,
  parameter int WAYS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_payload,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_payload,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_wdata
);

  localparam int ROW_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int AW    = (WAYS < MAX_WAYS) ? WAYS : MAX_WAYS;
  localparam int IW    = (AW > 1) ? $clog2(AW) : 1;
  localparam int ENT_W = $bits(way_ent_t);

  typedef way_ent_t [WAYS-1:0] row_t;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_LOOK  = 3'b100
  } state_t;

  // Row of the memory that a set code lands on, computed at elaboration.
  function automatic int row_of(input int s);
    int r;
    r = s;
    for (int k = 0; k < SET_CODES; k++) begin
      if (r >= SETS) begin
        r = r - SETS;
      end
    end
    return r;
  endfunction

  logic [ROW_W-1:0] row_map [SET_CODES];

  for (genvar g = 0; g < SET_CODES; g++) begin : g_row_map
    assign row_map[g] = ROW_W'(row_of(g));
  end

  state_t state_r, state_nxt;

  logic [2:0]  set_bits_r;
  logic [4:0]  block_bits_r;
  logic [3:0]  ways_r;

  logic [31:0] hits_r, misses_r, evicts_r, accesses_r;
  logic [31:0] hits_nxt, misses_nxt, evicts_nxt, accesses_nxt;

  logic [ROW_W-1:0] clr_cnt_r;
  logic [ROW_W-1:0] row_idx_r;
  logic [5:0]       set_r;
  logic [31:0]      tag_r;
  logic [25:0]      off_r;
  logic             modify_r;
  logic             pass2_r;
  row_t             fwd_r;

  logic             out_valid_r;
  out_beat_t        out_r;

  // Effective configuration values.
  logic [2:0] s_eff;
  logic [4:0] b_eff;
  logic [5:0] sb_eff;
  logic [3:0] nw;

  always_comb begin
    s_eff  = (set_bits_r > SET_BITS_MAX) ? SET_BITS_MAX : set_bits_r;
    b_eff  = (block_bits_r > BLOCK_BITS_MAX) ? BLOCK_BITS_MAX : block_bits_r;
    sb_eff = 6'(s_eff) + 6'(b_eff);
    nw     = (ways_r == 4'd0) ? 4'd1 : ways_r;
    if (nw > 4'(AW)) begin
      nw = 4'(AW);
    end
  end

  // Address split of the incoming beat.
  logic [31:0] addr_sh;
  logic [5:0]  set_in;
  logic [31:0] tag_in;
  logic [25:0] off_in;

  always_comb begin
    addr_sh = in_payload.address >> b_eff;
    set_in  = addr_sh[5:0] & 6'((7'd1 << s_eff) - 7'd1);
    off_in  = in_payload.address[25:0] & 26'((27'd1 << b_eff) - 27'd1);
    tag_in  = in_payload.address >> sb_eff;
  end

  logic in_acc;
  logic out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // Row memory.
  logic             ram_we;
  logic [ROW_W-1:0] ram_waddr;
  row_t             ram_wdata;
  logic             ram_re;
  row_t             ram_rdata;

  salc_ram #(
    .WIDTH (WAYS * ENT_W),
    .DEPTH (SETS)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (row_map[set_in]),
    .rdata (ram_rdata)
  );

  // Lookup, victim choice and rank update of the current row.
  row_t          row_cur, row_new;
  logic          act;
  logic          hit, emp;
  logic [IW-1:0] hit_idx, emp_idx, best_idx, victim, keep;
  logic [2:0]    best_rank, lim;
  logic [31:0]   evicted;
  logic [1:0]    outcome;
  logic          do_step;

  always_comb begin
    row_cur   = pass2_r ? fwd_r : ram_rdata;
    row_new   = row_cur;
    act       = 1'b0;
    hit       = 1'b0;
    emp       = 1'b0;
    hit_idx   = '0;
    emp_idx   = '0;
    best_idx  = '0;
    best_rank = row_cur[0].rank;
    for (int i = 0; i < AW; i++) begin
      act = (4'(i) < nw);
      if (act && row_cur[i].valid && row_cur[i].tag == tag_r && !hit) begin
        hit     = 1'b1;
        hit_idx = IW'(i);
      end
      if (act && !row_cur[i].valid && !emp) begin
        emp     = 1'b1;
        emp_idx = IW'(i);
      end
    end
    for (int i = 1; i < AW; i++) begin
      act = (4'(i) < nw);
      if (act && row_cur[i].rank > best_rank) begin
        best_rank = row_cur[i].rank;
        best_idx  = IW'(i);
      end
    end
    lim    = row_cur[hit_idx].rank;
    victim = emp ? emp_idx : best_idx;
    keep   = hit ? hit_idx : victim;
    for (int i = 0; i < AW; i++) begin
      act = (4'(i) < nw);
      if (act && IW'(i) != keep && row_cur[i].valid && (!hit || row_cur[i].rank < lim)
          && row_cur[i].rank != RANK_MAX) begin
        row_new[i].rank = row_cur[i].rank + 3'd1;
      end
    end
    row_new[keep].rank = 3'd0;
    if (!hit) begin
      row_new[keep].valid = 1'b1;
      row_new[keep].tag   = tag_r;
    end
    evicted = (!hit && !emp) ? row_cur[victim].tag : 32'd0;
    if (hit) begin
      outcome = OUT_HIT;
    end else if (emp) begin
      outcome = OUT_FILL;
    end else begin
      outcome = OUT_EVICT;
    end
  end

  assign do_step = (state_r == S_LOOK) && out_free;

  // Saturating running counters.
  always_comb begin
    accesses_nxt = (accesses_r == '1) ? accesses_r : accesses_r + 32'd1;
    hits_nxt     = hits_r;
    misses_nxt   = misses_r;
    evicts_nxt   = evicts_r;
    if (hit) begin
      hits_nxt = (hits_r == '1) ? hits_r : hits_r + 32'd1;
    end else begin
      misses_nxt = (misses_r == '1) ? misses_r : misses_r + 32'd1;
    end
    if (outcome == OUT_EVICT) begin
      evicts_nxt = (evicts_r == '1) ? evicts_r : evicts_r + 32'd1;
    end
  end

  // Memory port control: row read, clearing pass or write-back of the updated row.
  always_comb begin
    ram_re    = in_acc && (in_payload.mode != MODE_NONE);
    ram_we    = 1'b0;
    ram_waddr = row_idx_r;
    ram_wdata = row_new;
    if (state_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else if (do_step) begin
      ram_we = 1'b1;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_cnt_r == ROW_W'(SETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc && in_payload.mode != MODE_NONE) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (do_step && !(modify_r && !pass2_r)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      set_bits_r   <= 3'd0;
      block_bits_r <= 5'd0;
      ways_r       <= 4'd1;
      hits_r       <= '0;
      misses_r     <= '0;
      evicts_r     <= '0;
      accesses_r   <= '0;
      pass2_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + ROW_W'(1);
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SET_BITS:   set_bits_r   <= cfg_wdata[2:0];
          CFG_BLOCK_BITS: block_bits_r <= cfg_wdata;
          CFG_WAYS:       ways_r       <= cfg_wdata[3:0];
          default: ;
        endcase
      end
      if (do_step) begin
        hits_r     <= hits_nxt;
        misses_r   <= misses_nxt;
        evicts_r   <= evicts_nxt;
        accesses_r <= accesses_nxt;
        pass2_r    <= modify_r && !pass2_r;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      set_r     <= set_in;
      tag_r     <= tag_in;
      off_r     <= off_in;
      modify_r  <= (in_payload.mode == MODE_MODIFY);
      row_idx_r <= row_map[set_in];
    end
    if (do_step) begin
      fwd_r                <= row_new;
      out_r.outcome        <= outcome;
      out_r.set_index      <= set_r;
      out_r.line_tag       <= tag_r;
      out_r.blk_off        <= off_r;
      out_r.evicted_tag    <= evicted;
      out_r.last           <= !(modify_r && !pass2_r);
      out_r.hit_count      <= hits_nxt;
      out_r.miss_count     <= misses_nxt;
      out_r.eviction_count <= evicts_nxt;
      out_r.access_count   <= accesses_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

endmodule

[rtl/core/salc_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read data.
// Stand-alone; no package needed.
module salc_ram #(
  parameter int WIDTH = 288,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and read data that holds while no read is issued.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
